// ----- rtl/transformed_box_bounds_union_macros.svh -----
// assertion macros for the transformed box bounds union
`ifndef TRANSFORMED_BOX_BOUNDS_UNION_MACROS_SVH
`define TRANSFORMED_BOX_BOUNDS_UNION_MACROS_SVH
`ifndef SYNTH
`define TBBU_ASSERT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);
`define TBBU_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);
`else
`define TBBU_ASSERT(lbl, clk, rstn, ante, cons, msg)
`define TBBU_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

// ----- rtl/tbbu_pkg.sv -----
// shared types and constants for the transformed box bounds union
`default_nettype none
package tbbu_pkg;
	localparam int DATA_W = 32;
	localparam int CMD_W = 2;
	localparam int IDX_W = 4;
	localparam int ELEM_COUNT = 12;
	localparam int SUM_W = 2 * DATA_W + 2;
	localparam int COORD_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF = 16;

	localparam int OPQ_DEPTH = 4;
	localparam int OPQ_PTR_W = $clog2(OPQ_DEPTH);
	localparam int OPQ_CNT_W = $clog2(OPQ_DEPTH + 1);
	localparam int RESQ_DEPTH = 2;
	localparam int RESQ_PTR_W = $clog2(RESQ_DEPTH);
	localparam int RESQ_CNT_W = $clog2(RESQ_DEPTH + 1);

	typedef enum logic [CMD_W-1:0] {
		CMD_LOAD  = 2'd0,
		CMD_MERGE = 2'd1,
		CMD_EMIT  = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		OP_LOAD  = 2'd0,
		OP_MERGE = 2'd1,
		OP_EMIT  = 2'd2
	} op_kind_t;

	typedef struct packed {
		op_kind_t                kind;
		logic [IDX_W-1:0]        idx;
		logic [DATA_W-1:0]       value;
		logic [2:0][DATA_W-1:0]  lo;
		logic [2:0][DATA_W-1:0]  hi;
	} op_t;

	typedef struct packed {
		logic [2:0][DATA_W-1:0]  lo;
		logic [2:0][DATA_W-1:0]  hi;
		logic                    nonempty;
	} res_t;
endpackage
`default_nettype wire

// ----- rtl/transformed_box_bounds_union.sv -----
// Transformed box bounds union: affine transform of boxes merged into a running union.
// Requests enter through a queue port: push with full; a request is taken at a clock
// edge with push high and full low. cmd 0 loads one 3x4 matrix element, cmd 1 merges
// the eight transformed corners of a box into the union, cmd 2 emits the union and
// clears it; loads with an element index of 12 or more and cmd 3 are dropped.
// Results leave through a queue port: empty with pop; the oldest result is on the
// union ports while empty is low and leaves at an edge with pop high and empty low.
// A four-entry request queue parts the front end from the execution side.
// A box is merged one corner per cycle through nine 32x32 multipliers and the
// three-stage corner pipeline; an emit waits until that pipeline drains and the
// result queue has room. An emit's result is written into the result queue
// when the emit leaves the request queue.
// Reset loads the identity matrix and an empty union and clears both queues.
// When the receiver stalls, two results wait in the result queue; the block keeps
// taking loads and boxes, and requests back up only behind a third emit.
`default_nettype none
module transformed_box_bounds_union import tbbu_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	output logic                     full,
	input  logic [CMD_W-1:0]         cmd,
	input  logic [IDX_W-1:0]         elem_index,
	input  logic signed [DATA_W-1:0] elem_value,
	input  logic signed [DATA_W-1:0] box_min_x,
	input  logic signed [DATA_W-1:0] box_min_y,
	input  logic signed [DATA_W-1:0] box_min_z,
	input  logic signed [DATA_W-1:0] box_max_x,
	input  logic signed [DATA_W-1:0] box_max_y,
	input  logic signed [DATA_W-1:0] box_max_z,
	output logic                     empty,
	input  logic                     pop,
	output logic signed [DATA_W-1:0] union_min_x,
	output logic signed [DATA_W-1:0] union_min_y,
	output logic signed [DATA_W-1:0] union_min_z,
	output logic signed [DATA_W-1:0] union_max_x,
	output logic signed [DATA_W-1:0] union_max_y,
	output logic signed [DATA_W-1:0] union_max_z,
	output logic                     nonempty
);
	op_t  head;
	logic head_valid, head_take;
	res_t res_head;

	tbbu_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.cmd        (cmd),
		.elem_index (elem_index),
		.elem_value (elem_value),
		.box_min_x  (box_min_x),
		.box_min_y  (box_min_y),
		.box_min_z  (box_min_z),
		.box_max_x  (box_max_x),
		.box_max_y  (box_max_y),
		.box_max_z  (box_max_z),
		.head       (head),
		.head_valid (head_valid),
		.head_take  (head_take)
	);

	tbbu_back #(
		.COORD_WIDTH (COORD_WIDTH),
		.FRAC_BITS   (FRAC_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (head_valid),
		.head_take  (head_take),
		.res_head   (res_head),
		.res_empty  (empty),
		.res_pop    (pop)
	);

	assign union_min_x = signed'(res_head.lo[0]);
	assign union_min_y = signed'(res_head.lo[1]);
	assign union_min_z = signed'(res_head.lo[2]);
	assign union_max_x = signed'(res_head.hi[0]);
	assign union_max_y = signed'(res_head.hi[1]);
	assign union_max_z = signed'(res_head.hi[2]);
	assign nonempty = res_head.nonempty;
endmodule
`default_nettype wire

// ----- rtl/tbbu_front.sv -----
// front end: request decode, filtering and the operation queue
`default_nettype none
module tbbu_front import tbbu_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	output logic                     full,
	input  logic [CMD_W-1:0]         cmd,
	input  logic [IDX_W-1:0]         elem_index,
	input  logic signed [DATA_W-1:0] elem_value,
	input  logic signed [DATA_W-1:0] box_min_x,
	input  logic signed [DATA_W-1:0] box_min_y,
	input  logic signed [DATA_W-1:0] box_min_z,
	input  logic signed [DATA_W-1:0] box_max_x,
	input  logic signed [DATA_W-1:0] box_max_y,
	input  logic signed [DATA_W-1:0] box_max_z,
	output op_t                      head,
	output logic                     head_valid,
	input  logic                     head_take
);
	op_t                  op_mem_q [OPQ_DEPTH];
	logic [OPQ_PTR_W-1:0] wr_q, rd_q;
	logic [OPQ_CNT_W-1:0] cnt_q;
	op_t                  dec;
	logic                 keep;
	logic                 enq, deq;

	always_comb begin
		dec.idx = elem_index;
		dec.value = elem_value;
		dec.lo = {box_min_z, box_min_y, box_min_x};
		dec.hi = {box_max_z, box_max_y, box_max_x};
		dec.kind = OP_LOAD;
		keep = 1'b0;
		unique case (cmd_t'(cmd))
			CMD_LOAD: begin
				dec.kind = OP_LOAD;
				// out of range element indexes are dropped here
				keep = (elem_index < IDX_W'(ELEM_COUNT));
			end
			CMD_MERGE: begin
				dec.kind = OP_MERGE;
				keep = 1'b1;
			end
			CMD_EMIT: begin
				dec.kind = OP_EMIT;
				keep = 1'b1;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	assign full = (cnt_q == OPQ_CNT_W'(OPQ_DEPTH));
	assign enq = push && !full && keep;
	assign deq = head_take && head_valid;
	assign head_valid = (cnt_q != '0);
	assign head = op_mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (enq)
				wr_q <= wr_q + 1'b1;
			if (deq)
				rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + OPQ_CNT_W'(enq) - OPQ_CNT_W'(deq);
		end
	end

	always_ff @(posedge clk) begin
		if (enq)
			op_mem_q[wr_q] <= dec;
	end
endmodule
`default_nettype wire

// ----- rtl/tbbu_back.sv -----
// back end: matrix store, corner pipeline, running union and result queue
`default_nettype none
`include "transformed_box_bounds_union_macros.svh"
module tbbu_back import tbbu_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  op_t  head,
	input  logic head_valid,
	output logic head_take,
	output res_t res_head,
	output logic res_empty,
	input  logic res_pop
);
	localparam logic signed [SUM_W-1:0] SUM_MAX =
		{{(SUM_W-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] SUM_MIN =
		{{(SUM_W-COORD_WIDTH+1){1'b1}}, {(COORD_WIDTH-1){1'b0}}};
	localparam logic signed [COORD_WIDTH-1:0] CMAX_C = {1'b0, {(COORD_WIDTH-1){1'b1}}};
	localparam logic signed [COORD_WIDTH-1:0] CMIN_C = {1'b1, {(COORD_WIDTH-1){1'b0}}};
	localparam logic signed [DATA_W-1:0] ONE_Q = DATA_W'(1) << FRAC_BITS;

	logic signed [DATA_W-1:0]      mat_q [ELEM_COUNT];
	logic [2:0]                    corner_q;
	logic                          v_s1, v_s2, v_s3;
	logic signed [2*DATA_W-1:0]    prod_s1 [3][3];
	logic signed [DATA_W-1:0]      trans_s1 [3];
	logic signed [SUM_W-1:0]       sum_s2 [3];
	logic signed [COORD_WIDTH-1:0] sat_s3 [3];
	logic signed [COORD_WIDTH-1:0] run_min_q [3];
	logic signed [COORD_WIDTH-1:0] run_max_q [3];
	logic                          seen_q;

	res_t                  res_mem_q [RESQ_DEPTH];
	logic [RESQ_PTR_W-1:0] res_wr_q, res_rd_q;
	logic [RESQ_CNT_W-1:0] res_cnt_q;

	logic signed [DATA_W-1:0] pt [3];
	logic                     issue, load_take, emit_take, pipe_busy, res_full, res_deq;
	logic signed [63:0]       ext_min [3];
	logic signed [63:0]       ext_max [3];
	res_t                     res_new;

	assign pipe_busy = v_s1 || v_s2 || v_s3;
	assign res_full = (res_cnt_q == RESQ_CNT_W'(RESQ_DEPTH));
	assign res_empty = (res_cnt_q == '0);
	assign res_deq = res_pop && !res_empty;
	assign res_head = res_mem_q[res_rd_q];

	always_comb begin
		issue = 1'b0;
		load_take = 1'b0;
		emit_take = 1'b0;
		if (head_valid) begin
			unique case (head.kind)
				OP_LOAD:  load_take = 1'b1;
				OP_MERGE: issue = 1'b1;
				OP_EMIT:  emit_take = !pipe_busy && !res_full;
				default:  load_take = 1'b0;
			endcase
		end
	end
	// a box leaves the queue with its last corner
	assign head_take = load_take || emit_take || (issue && corner_q == 3'd7);

	always_comb begin
		for (int k = 0; k < 3; k++)
			pt[k] = corner_q[k] ? signed'(head.hi[k]) : signed'(head.lo[k]);
	end

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			ext_min[a] = 64'(run_min_q[a]);
			ext_max[a] = 64'(run_max_q[a]);
			res_new.lo[a] = ext_min[a][DATA_W-1:0];
			res_new.hi[a] = ext_max[a][DATA_W-1:0];
		end
		res_new.nonempty = seen_q;
	end

	// datapath registers
	always_ff @(posedge clk) begin
		for (int r = 0; r < 3; r++) begin
			for (int k = 0; k < 3; k++)
				prod_s1[r][k] <= mat_q[r*4+k] * pt[k];
			trans_s1[r] <= mat_q[r*4+3];
			// arithmetic shift floors the products
			sum_s2[r] <= SUM_W'(prod_s1[r][0] >>> FRAC_BITS)
				+ SUM_W'(prod_s1[r][1] >>> FRAC_BITS)
				+ SUM_W'(prod_s1[r][2] >>> FRAC_BITS)
				+ SUM_W'(trans_s1[r]);
			if (sum_s2[r] > SUM_MAX)
				sat_s3[r] <= CMAX_C;
			else if (sum_s2[r] < SUM_MIN)
				sat_s3[r] <= CMIN_C;
			else
				sat_s3[r] <= sum_s2[r][COORD_WIDTH-1:0];
		end
		if (emit_take)
			res_mem_q[res_wr_q] <= res_new;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			// identity on the diagonal, zero elsewhere
			for (int i = 0; i < ELEM_COUNT; i++)
				mat_q[i] <= (i == 0 || i == 5 || i == 10) ? ONE_Q : '0;
			corner_q <= '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			for (int a = 0; a < 3; a++) begin
				run_min_q[a] <= CMAX_C;
				run_max_q[a] <= CMIN_C;
			end
			seen_q <= 1'b0;
			res_wr_q <= '0;
			res_rd_q <= '0;
			res_cnt_q <= '0;
		end else begin
			if (load_take)
				mat_q[head.idx] <= signed'(head.value);
			if (issue)
				corner_q <= corner_q + 3'd1;
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (emit_take) begin
				for (int a = 0; a < 3; a++) begin
					run_min_q[a] <= CMAX_C;
					run_max_q[a] <= CMIN_C;
				end
				seen_q <= 1'b0;
			end else if (v_s3) begin
				for (int a = 0; a < 3; a++) begin
					if (sat_s3[a] < run_min_q[a])
						run_min_q[a] <= sat_s3[a];
					if (sat_s3[a] > run_max_q[a])
						run_max_q[a] <= sat_s3[a];
				end
				seen_q <= 1'b1;
			end
			if (emit_take)
				res_wr_q <= res_wr_q + 1'b1;
			if (res_deq)
				res_rd_q <= res_rd_q + 1'b1;
			res_cnt_q <= res_cnt_q + RESQ_CNT_W'(emit_take) - RESQ_CNT_W'(res_deq);
		end
	end

	`TBBU_ASSERT_NEXT(a_emit_clears, clk, arst_n, emit_take, !seen_q && run_min_q[0] == CMAX_C && run_max_q[2] == CMIN_C, "union not cleared after emit")
	`TBBU_ASSERT_NEXT(a_corner_marks_seen, clk, arst_n, v_s3, seen_q, "merged corner did not mark union")
	`TBBU_ASSERT(a_corner_on_box, clk, arst_n, corner_q != 3'd0, head_valid && head.kind == OP_MERGE, "corner count left over without a box")
	`TBBU_ASSERT(a_res_bound, clk, arst_n, 1'b1, res_cnt_q <= RESQ_CNT_W'(RESQ_DEPTH), "result queue overflow")
endmodule
`default_nettype wire
